// ===== hw/rtl/pcx_pkg.sv =====
package pcx_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_PALETTE   = 2'd0;
    localparam logic [1:0] KIND_DATA      = 2'd1;
    localparam logic [1:0] KIND_NEW_IMAGE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PLANAR_MODE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 13;

    // A byte at or above this value introduces a run.
    localparam logic [7:0] RUN_HEADER = 8'd192;
    localparam logic [7:0] RUN_MASK   = 8'h3F;

    localparam logic [1:0] NUM_PLANES = 2'd3;

    localparam int PAL_DEPTH = 256;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] palette_slot;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } pcx_item_t;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [1:0]  plane;
        logic        whole_pixel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
        logic        overrun;
        logic        image_done;
    } pcx_pixel_t;

    typedef struct packed {
        logic                  planar_mode;
        logic [CFG_DATA_W-1:0] image_width;
        logic [CFG_DATA_W-1:0] image_height;
    } pcx_cfg_t;

    typedef enum logic [1:0] {
        OP_PALETTE,
        OP_DATA,
        OP_NEW_IMAGE
    } pcx_op_kind_t;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        pcx_op_kind_t op;
        logic         run_hdr;
        logic [7:0]   value;
        logic [7:0]   slot;
        logic [23:0]  rgb;
    } pcx_entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } pcx_state_t;

endpackage

// ===== hw/rtl/pcx_rle_pixel_decoder_core.sv =====
// A value byte passes through the queue, the back end's run registers and registered
// palette read, and the output register. The back end takes a new item from the queue
// only while idle; during a run it loads one result per cycle into the single output
// register unless pixel_stall holds it. A two-beat queue lets the input run ahead of the back end.
// Reset clears the position, run and queue state and sets width and height to one;
// the palette is not cleared and reads undefined until each entry is loaded.
module pcx_rle_pixel_decoder_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  pcx_pkg::pcx_item_t                  item,
    output logic                                pixel_valid,
    input  logic                                pixel_stall,
    output pcx_pkg::pcx_pixel_t                 pixel,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [pcx_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pcx_pkg::*;

    pcx_cfg_t   cfg_reg, cfg_next;
    pcx_entry_t push_entry, head_entry;
    logic       q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PLANAR_MODE:  cfg_next.planar_mode  = cfg_data[0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.planar_mode  <= 1'b0;
            cfg_reg.image_width  <= CFG_DATA_W'(1);
            cfg_reg.image_height <= CFG_DATA_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcx_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    pcx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    pcx_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (!q_empty),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

`ifndef SYNTH
    // The back end only takes a beat that the queue holds.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // The final result of an image always closes its item.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel.image_done) |-> pixel.last)
        else $error("image_done without last");

    // Results follow the configured mode.
    a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (pixel.whole_pixel != cfg_reg.planar_mode))
        else $error("whole_pixel does not match the mode");

    // Planar results only ever name one of the three colour planes.
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel.whole_pixel) |-> (pixel.plane != 2'd3))
        else $error("plane out of range");
`endif

endmodule

// ===== hw/rtl/pcx_front.sv =====
module pcx_front (
    input  logic                item_valid,
    output logic                item_stall,
    input  pcx_pkg::pcx_item_t  item,
    input  logic                q_full,
    output logic                q_push,
    output pcx_pkg::pcx_entry_t q_entry
);
    import pcx_pkg::*;

    assign item_stall = q_full;

    always_comb
    begin
        q_entry.op      = OP_DATA;
        q_entry.run_hdr = (item.data_byte >= RUN_HEADER);
        q_entry.value   = item.data_byte;
        q_entry.slot    = item.palette_slot;
        q_entry.rgb     = {item.palette_red, item.palette_green, item.palette_blue};
        q_push          = 1'b0;
        case (item.kind)
            KIND_PALETTE:
            begin
                q_entry.op = OP_PALETTE;
                q_push     = item_valid && !q_full;
            end
            KIND_DATA:
            begin
                q_entry.op = OP_DATA;
                q_push     = item_valid && !q_full;
            end
            KIND_NEW_IMAGE:
            begin
                q_entry.op = OP_NEW_IMAGE;
                q_push     = item_valid && !q_full;
            end
            // The unused kind is taken and dropped here.
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pcx_queue.sv =====
module pcx_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pcx_pkg::pcx_entry_t push_entry,
    input  logic                pop,
    output pcx_pkg::pcx_entry_t head_entry,
    output logic                full,
    output logic                empty
);
    import pcx_pkg::*;

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    pcx_entry_t             slots_reg [QUEUE_DEPTH];

    assign full       = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/pcx_back.sv =====
module pcx_back #(
    parameter int MAX_DIM = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcx_pkg::pcx_cfg_t   cfg,
    input  logic                q_valid,
    input  pcx_pkg::pcx_entry_t q_entry,
    output logic                q_pop,
    output logic                pixel_valid,
    input  logic                pixel_stall,
    output pcx_pkg::pcx_pixel_t pixel
);
    import pcx_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = (2 * CNT_W > 24) ? 2 * CNT_W : 24;

    // Control state.
    pcx_state_t        state_reg, state_next;
    logic              awaiting_reg, awaiting_next;
    logic [5:0]        held_reg, held_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [1:0]        plane_reg, plane_next;
    logic              finished_reg, finished_next;
    logic [5:0]        len_reg, len_next;
    logic              first_reg, first_next;
    logic              out_valid_reg, out_valid_next;

    // Run payload and output data.
    logic [7:0]        value_reg, value_next;
    logic [23:0]       base_reg, base_next;
    logic [PROD_W-1:0] lim_reg, lim_next;
    logic              clip_reg, clip_next;
    pcx_pixel_t        out_reg, out_next;

    logic [23:0]       pal_mem [PAL_DEPTH];
    logic [23:0]       pal_rd_reg;
    logic              pal_we, pal_re;

    logic [CNT_W-1:0]  w_eff, h_eff;
    logic [CNT_W-1:0]  rows_left;
    logic [PROD_W-1:0] base_prod, lim_prod, rem;
    logic              clip_now, can_load;
    logic [CNT_W-1:0]  col_inc, row_inc;
    logic [1:0]        plane_inc;
    logic              wrap, row_adv, done, last;

    // Out-of-range dimensions are clamped to one and to the maximum.
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (32'(cfg.image_width) > MAX_DIM)
        begin
            w_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            w_eff = CNT_W'(cfg.image_width);
        end

        if (cfg.image_height == '0)
        begin
            h_eff = CNT_W'(1);
        end
        else if (32'(cfg.image_height) > MAX_DIM)
        begin
            h_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            h_eff = CNT_W'(cfg.image_height);
        end
    end

    // Row base and remaining room are multiplied out in the cycle a run starts.
    assign rows_left = h_eff - row_reg;
    assign base_prod = PROD_W'(row_reg) * PROD_W'(w_eff);
    assign lim_prod  = cfg.planar_mode ? PROD_W'(w_eff)
                                       : PROD_W'(rows_left) * PROD_W'(w_eff);

    // The clip decision is made on the first beat and held for the rest of the run.
    assign rem      = lim_reg - PROD_W'(col_reg);
    assign clip_now = first_reg ? (PROD_W'(len_reg) > rem) : clip_reg;

    assign col_inc   = col_reg + 1'b1;
    assign row_inc   = row_reg + 1'b1;
    assign plane_inc = plane_reg + 1'b1;
    assign wrap      = (col_inc >= w_eff);
    assign row_adv   = cfg.planar_mode ? (wrap && (plane_inc >= NUM_PLANES)) : wrap;
    assign done      = row_adv && (row_inc >= h_eff);
    assign last      = (len_reg == 6'd1) || done
                       || (clip_now && (cfg.planar_mode ? wrap : done));

    assign can_load = !out_valid_reg || !pixel_stall;

    always_comb
    begin
        state_next     = state_reg;
        awaiting_next  = awaiting_reg;
        held_next      = held_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        plane_next     = plane_reg;
        finished_next  = finished_reg;
        len_next       = len_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && pixel_stall;
        value_next     = value_reg;
        base_next      = base_reg;
        lim_next       = lim_reg;
        clip_next      = clip_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        pal_we         = 1'b0;
        pal_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_entry.op)
                        OP_PALETTE:
                        begin
                            pal_we = 1'b1;
                        end
                        OP_NEW_IMAGE:
                        begin
                            awaiting_next = 1'b0;
                            held_next     = '0;
                            row_next      = '0;
                            col_next      = '0;
                            plane_next    = '0;
                            finished_next = 1'b0;
                        end
                        OP_DATA:
                        begin
                            if (!finished_reg)
                            begin
                                if (row_reg >= h_eff || col_reg >= w_eff)
                                begin
                                    // The image shrank under the current position.
                                    finished_next = 1'b1;
                                    awaiting_next = 1'b0;
                                end
                                else if (!awaiting_reg && q_entry.run_hdr)
                                begin
                                    held_next     = 6'(q_entry.value & RUN_MASK);
                                    awaiting_next = 1'b1;
                                end
                                else
                                begin
                                    awaiting_next = 1'b0;
                                    len_next      = awaiting_reg ? held_reg : 6'd1;
                                    first_next    = 1'b1;
                                    pal_re        = 1'b1;
                                    value_next    = q_entry.value;
                                    base_next     = 24'(base_prod);
                                    lim_next      = lim_prod;
                                    // A zero-length run gives nothing.
                                    if (len_next != '0)
                                    begin
                                        state_next = ST_EMIT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next       = 1'b1;
                    out_next.pixel_index = base_reg + 24'(col_reg);
                    out_next.last        = last;
                    out_next.overrun     = clip_now;
                    out_next.image_done  = done;
                    if (cfg.planar_mode)
                    begin
                        out_next.plane       = plane_reg;
                        out_next.whole_pixel = 1'b0;
                        out_next.red         = (plane_reg == 2'd0) ? value_reg : 8'd0;
                        out_next.green       = (plane_reg == 2'd1) ? value_reg : 8'd0;
                        out_next.blue        = (plane_reg == 2'd2) ? value_reg : 8'd0;
                        if (wrap)
                        begin
                            plane_next = (plane_inc >= NUM_PLANES) ? 2'd0 : plane_inc;
                        end
                    end
                    else
                    begin
                        out_next.plane       = 2'd0;
                        out_next.whole_pixel = 1'b1;
                        out_next.red         = pal_rd_reg[23:16];
                        out_next.green       = pal_rd_reg[15:8];
                        out_next.blue        = pal_rd_reg[7:0];
                    end
                    col_next   = wrap ? '0 : col_inc;
                    first_next = 1'b0;
                    clip_next  = clip_now;
                    len_next   = len_reg - 1'b1;
                    if (row_adv)
                    begin
                        row_next  = row_inc;
                        base_next = base_reg + 24'(w_eff);
                    end
                    if (done)
                    begin
                        finished_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            awaiting_reg  <= 1'b0;
            held_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            plane_reg     <= '0;
            finished_reg  <= 1'b0;
            len_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            awaiting_reg  <= awaiting_next;
            held_reg      <= held_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            plane_reg     <= plane_next;
            finished_reg  <= finished_next;
            len_reg       <= len_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        base_reg  <= base_next;
        lim_reg   <= lim_next;
        clip_reg  <= clip_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[q_entry.slot] <= q_entry.rgb;
        end
        if (pal_re)
        begin
            pal_rd_reg <= pal_mem[q_entry.value];
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import pcx_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned DIM_LIMIT = 4096;
    localparam int unsigned IDLE_PCT = 34;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned ITEM_TARGET = 210;
    localparam int unsigned QUIET_ITEMS = 50;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    pcx_item_t             item = '0;
    logic                  pixel_valid;
    logic                  pixel_stall = 1'b0;
    pcx_pixel_t            pixel;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pcx_rle_pixel_decoder_core #(
        .MAX_DIM(DIM_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Decoder state as the testbench expects it to be.
    logic [23:0]           pal_rgb [PAL_DEPTH];
    bit                    pal_loaded [PAL_DEPTH];
    bit                    run_pending;
    logic [5:0]            run_len;
    int unsigned           row_pos;
    int unsigned           col_pos;
    int unsigned           plane_pos;
    bit                    img_finished;
    bit                    mode_planar;
    logic [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(1);
    logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(1);
    pcx_pixel_t            expected_pixels [$];

    bit          tx_quiet;
    bit          rx_quiet;
    bit          hold_req;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned live_items;
    int unsigned beats_checked;
    pcx_pixel_t  want_px;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return 32'(v);
    endfunction

    function automatic void restart_image();
        run_pending = 1'b0;
        run_len = '0;
        row_pos = 0;
        col_pos = 0;
        plane_pos = 0;
        img_finished = 1'b0;
    endfunction

    // Returns 1 unless the decoder simply drops the item.
    function automatic bit decode_item(pcx_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned len;
        int unsigned remaining;
        int unsigned i;
        bit          clipped;
        bit          ends;
        pcx_pixel_t  px;
        if (it.kind == KIND_PALETTE)
        begin
            pal_rgb[it.palette_slot] = {it.palette_red, it.palette_green, it.palette_blue};
            pal_loaded[it.palette_slot] = 1'b1;
            return 1'b1;
        end
        if (it.kind == KIND_NEW_IMAGE)
        begin
            restart_image();
            return 1'b1;
        end
        if (it.kind != KIND_DATA || img_finished)
            return 1'b0;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        // The image shrank beneath the current position.
        if (row_pos >= h || col_pos >= w)
        begin
            img_finished = 1'b1;
            run_pending = 1'b0;
            return 1'b1;
        end
        if (!run_pending && it.data_byte >= RUN_HEADER)
        begin
            run_len = 6'(it.data_byte & RUN_MASK);
            run_pending = 1'b1;
            return 1'b1;
        end
        len = run_pending ? 32'(run_len) : 1;
        run_pending = 1'b0;
        if (len == 0)
            return 1'b1;
        remaining = mode_planar ? w - col_pos : (h - row_pos) * w - col_pos;
        clipped = len > remaining;
        if (clipped)
            len = remaining;
        for (i = 0; i < len; i++)
        begin
            px = '0;
            ends = 1'b0;
            px.pixel_index = 24'(row_pos * w + col_pos);
            if (mode_planar)
            begin
                px.plane = 2'(plane_pos);
                if (plane_pos == 0)
                    px.red = it.data_byte;
                else if (plane_pos == 1)
                    px.green = it.data_byte;
                else
                    px.blue = it.data_byte;
                col_pos++;
                if (col_pos >= w)
                begin
                    col_pos = 0;
                    plane_pos++;
                    if (plane_pos >= NUM_PLANES)
                    begin
                        plane_pos = 0;
                        row_pos++;
                        ends = row_pos >= h;
                    end
                end
            end
            else
            begin
                px.whole_pixel = 1'b1;
                {px.red, px.green, px.blue} = pal_rgb[it.data_byte];
                col_pos++;
                if (col_pos >= w)
                begin
                    col_pos = 0;
                    row_pos++;
                    ends = row_pos >= h;
                end
            end
            px.last = (i + 1 == len) || ends;
            px.overrun = clipped;
            px.image_done = ends;
            expected_pixels.push_back(px);
            if (ends)
            begin
                img_finished = 1'b1;
                break;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit looks_up_palette(logic [7:0] code);
        if (mode_planar || img_finished)
            return 1'b0;
        if (row_pos >= clamp_dim(height_reg) || col_pos >= clamp_dim(width_reg))
            return 1'b0;
        return run_pending ? (run_len != 0) : (code < RUN_HEADER);
    endfunction

    function automatic pcx_item_t make_item(logic [1:0] kind, logic [7:0] code);
        pcx_item_t it;
        it.kind = kind;
        it.data_byte = code;
        it.palette_slot = 8'($urandom);
        it.palette_red = 8'($urandom);
        it.palette_green = 8'($urandom);
        it.palette_blue = 8'($urandom);
        return it;
    endfunction

    function automatic void check_field(string name, logic [23:0] want_v, logic [23:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic send_item(pcx_item_t it);
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        if (decode_item(it))
            live_items++;
    endtask

    task automatic send_palette(logic [7:0] slot, logic [23:0] rgb);
        pcx_item_t it;
        it = make_item(KIND_PALETTE, 8'($urandom));
        it.palette_slot = slot;
        {it.palette_red, it.palette_green, it.palette_blue} = rgb;
        send_item(it);
    endtask

    // A value that would hit an empty palette entry gets that entry loaded first.
    task automatic send_data(logic [7:0] code);
        if (looks_up_palette(code) && !pal_loaded[code])
            send_palette(code, 24'($urandom));
        send_item(make_item(KIND_DATA, code));
    endtask

    task automatic send_run(logic [5:0] len, logic [7:0] value);
        send_data(RUN_HEADER | {2'b00, len});
        send_data(value);
    endtask

    task automatic new_image();
        send_item(make_item(KIND_NEW_IMAGE, 8'($urandom)));
    endtask

    task automatic send_unused();
        send_item(make_item(KIND_UNUSED, 8'($urandom)));
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        // Palette loads and image restarts may still sit in the input queue.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_PLANAR_MODE)
            mode_planar = val[0];
        else if (idx == CFG_IMAGE_WIDTH)
            width_reg = val;
        else if (idx == CFG_IMAGE_HEIGHT)
            height_reg = val;
    endtask

    task automatic set_config(bit planar, logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_PLANAR_MODE, CFG_DATA_W'(planar));
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_after_reset();
        // Out of reset the image is one paletted pixel, so a full run clips to one.
        send_palette(8'hFF, 24'hFFFFFF);
        send_palette(8'h00, 24'h000000);
        send_run(6'h3F, 8'hFF);
        send_data(8'h00);
        wait_idle();
    endtask

    task automatic test_paletted_runs();
        set_config(1'b0, 4, 2);
        new_image();
        send_run(6'd3, 8'h00);
        send_run(6'd0, 8'h55);
        send_data(8'hBF);
        send_unused();
        send_run(6'h3F, 8'hFF);
        wait_idle();
    endtask

    task automatic test_planar_rows();
        set_config(1'b1, 3, 2);
        new_image();
        send_run(6'd2, 8'h80);
        send_data(8'h7F);
        send_run(6'd5, 8'hC0);
        send_run(6'd3, 8'h01);
        send_run(6'h3F, 8'hFE);
        send_data(8'h10);
        send_data(8'h20);
        send_data(8'h30);
        send_run(6'd3, 8'hFF);
        send_data(8'h11);
        wait_idle();
    endtask

    task automatic test_dimension_edges();
        set_config(1'b0, 0, 0);
        new_image();
        send_data(8'h01);
        send_data(8'h02);
        wait_idle();
        set_config(1'b1, 8191, 8191);
        new_image();
        send_run(6'h3F, 8'hAB);
        wait_idle();
        set_config(1'b0, 1, 4096);
        new_image();
        send_run(6'h3F, 8'h03);
        wait_idle();
        // Widening mid-image puts row 63 at the full stride.
        write_reg(CFG_IMAGE_WIDTH, 4096);
        send_run(6'h3F, 8'h04);
        wait_idle();
    endtask

    task automatic test_shrink_and_mode_switch();
        set_config(1'b0, 4, 4);
        new_image();
        send_run(6'd9, 8'h05);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_data(8'h06);
        send_data(8'h07);
        wait_idle();
        set_config(1'b1, 2, 2);
        new_image();
        send_data(8'h0A);
        send_data(8'h0B);
        send_data(8'h0C);
        wait_idle();
        // The plane count survives a detour through paletted mode.
        write_reg(CFG_PLANAR_MODE, 0);
        send_data(8'h20);
        wait_idle();
        write_reg(CFG_PLANAR_MODE, 1);
        send_data(8'h30);
        wait_idle();
    endtask

    task automatic test_receiver_hold();
        set_config(1'b0, 64, 4);
        new_image();
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        repeat (5) send_run(6'h3F, 8'($urandom));
        wait_idle();
        tx_quiet = 1'b0;
        hold_req = 1'b0;
    endtask

    task automatic test_random_streams();
        int unsigned start_sent;
        int unsigned phase_items;
        int unsigned r;
        int unsigned w;
        int unsigned h;
        bit          planar;
        start_sent = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            // The opening stretch of phases runs with neither side idling.
            tx_quiet = (items_sent - start_sent) < QUIET_ITEMS;
            rx_quiet = tx_quiet;
            planar = 1'($urandom_range(1));
            r = $urandom_range(9);
            if (r == 0)
            begin
                w = $urandom_range(4096, 1000);
                h = $urandom_range(3, 1);
            end
            else
            begin
                w = $urandom_range(10, 1);
                h = $urandom_range(5, 1);
            end
            set_config(planar, CFG_DATA_W'(w), CFG_DATA_W'(h));
            new_image();
            phase_items = 0;
            while (!img_finished && phase_items < 40 && items_sent < ITEM_TARGET)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    send_run($urandom_range(1) ? 6'($urandom_range(8)) : 6'($urandom_range(63)),
                             8'($urandom));
                else if (r < 80)
                    send_data(8'($urandom_range(191)));
                else if (r < 88)
                    send_palette(8'($urandom), 24'($urandom));
                else if (r < 93)
                    send_unused();
                else if (r < 97)
                    send_data(8'($urandom));
                else
                    new_image();
                phase_items++;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Result side: random stall, plus one long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            pixel_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            pixel_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            pixel_stall <= !rx_quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel beat with nothing expected, index %0d", pixel.pixel_index);
                fail_count++;
            end
            else
            begin
                want_px = expected_pixels.pop_front();
                check_field("pixel_index", want_px.pixel_index, pixel.pixel_index);
                check_field("plane", 24'(want_px.plane), 24'(pixel.plane));
                check_field("whole_pixel", 24'(want_px.whole_pixel), 24'(pixel.whole_pixel));
                check_field("red", 24'(want_px.red), 24'(pixel.red));
                check_field("green", 24'(want_px.green), 24'(pixel.green));
                check_field("blue", 24'(want_px.blue), 24'(pixel.blue));
                check_field("last", 24'(want_px.last), 24'(pixel.last));
                check_field("overrun", 24'(want_px.overrun), 24'(pixel.overrun));
                check_field("image_done", 24'(want_px.image_done), 24'(pixel.image_done));
                beats_checked++;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_paletted_runs();
        test_planar_rows();
        test_dimension_edges();
        test_shrink_and_mode_switch();
        test_receiver_hold();
        test_random_streams();
        wait_idle();
        $display("Decoded paletted and planar streams: clipped and empty runs, clamped sizes,");
        $display("mid-image changes and a long result hold-off; %0d items (%0d decoded), %0d pixel beats.",
                 items_sent, live_items, beats_checked);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
